FILE: design/tcpq_pkg.sv
// shared types and constants for the two-class priority queue
// used by tcpq_ctrl, tcpq_datapath and two_class_priority_queue_top
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd59;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PRIO   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take_item;    // latch the accepted beat, clear the result
        logic set_full;
        logic set_empty;
        logic append_write; // write at the tail, count up
        logic scan_start;   // walk pointer to the head
        logic scan_read;    // read entry at the walk pointer
        logic scan_next;    // step the walk pointer
        logic scan_stop;    // insert position found, walk pointer to the tail
        logic shift_read;   // read entry just below the walk pointer
        logic shift_write;  // move read entry up one slot, step down
        logic place_write;  // write new value at insert position, count up
        logic pop_read;     // read the head entry
        logic pop;          // take head value, advance head, count down
        logic load_out;     // move result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              item_high;
        logic              rd_high;
        logic              ptr_at_count;
        logic              ptr_at_pos;
        logic              out_free;
    } stat_t;

endpackage

FILE: design/two_class_priority_queue_top.sv
// top level of the two-class priority queue
// depends on tcpq_pkg, tcpq_ctrl and tcpq_datapath
`timescale 1ns / 1ps

// Ordered queue of up to QUEUE_DEPTH signed 32-bit values in a circular
// single-port-read memory. s_func selects append (0), priority insert (1) or
// remove head (2); code 3 does nothing. A priority insert of a value above
// cfg_priority_threshold lands behind the leading run of high entries. One
// item is worked at a time. The search for the insert position and the shift
// that makes room step one entry at a time through the memory's read port,
// reading an entry before each check or move. The result waits in an output
// register while the next beat is accepted; an item finishes only once that
// register is free again. The threshold register may be written only while
// the queue is idle.
module two_class_priority_queue_top
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [FUNC_W-1:0]          s_func,
    input  logic signed [DATA_W-1:0]   s_item_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic signed [DATA_W-1:0]   cfg_priority_threshold,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_removed_value,
    output logic [OCC_W-1:0]           m_occupancy
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    tcpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_func                 (s_func),
        .s_item_value           (s_item_value),
        .cfg_valid              (cfg_valid),
        .cfg_priority_threshold (cfg_priority_threshold),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_removed_value        (m_removed_value),
        .m_occupancy            (m_occupancy),
        .cmd                    (cmd),
        .stat                   (stat)
    );

endmodule

FILE: design/tcpq_ctrl.sv
// sequencer for the two-class priority queue
// depends on tcpq_pkg for the command and status structs and the operation codes
`timescale 1ns / 1ps

module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_SHIFT    = 8'b0001_0000,
        S_SHIFT_WR = 8'b0010_0000,
        S_POP      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (stat.func)
                    FN_APPEND, FN_PRIO: begin
                        if (stat.full) begin
                            cmd.set_full = 1'b1;
                        end else if (stat.func == FN_PRIO && stat.item_high) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else begin
                            cmd.append_write = 1'b1;
                        end
                    end
                    FN_REMOVE: begin
                        if (stat.empty) begin
                            cmd.set_empty = 1'b1;
                        end else begin
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP;
                        end
                    end
                    default: begin
                        // unused code, nothing to do
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.ptr_at_count) begin
                    cmd.scan_stop = 1'b1;
                    state_next    = S_SHIFT;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (stat.rd_high) begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN;
                end else begin
                    cmd.scan_stop = 1'b1;
                    state_next    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (stat.ptr_at_pos) begin
                    cmd.place_write = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    cmd.shift_read = 1'b1;
                    state_next     = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_write = 1'b1;
                state_next      = S_SHIFT;
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/tcpq_datapath.sv
// entry store, pointers, threshold and result registers of the priority queue
// depends on tcpq_pkg; driven by commands from tcpq_ctrl
`timescale 1ns / 1ps

module tcpq_datapath
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [FUNC_W-1:0]          s_func,
    input  logic signed [DATA_W-1:0]   s_item_value,
    input  logic                       cfg_valid,
    input  logic signed [DATA_W-1:0]   cfg_priority_threshold,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_removed_value,
    output logic [OCC_W-1:0]           m_occupancy,
    input  cmd_t                       cmd,
    output stat_t                      stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int OW = OCC_W + CW;

    // circular store, head at head_reg
    logic [DATA_W-1:0] mem [QUEUE_DEPTH];

    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic signed [DATA_W-1:0]   thr_reg, thr_next;
    logic [FUNC_W-1:0]          op_func_reg;
    logic signed [DATA_W-1:0]   op_value_reg;
    logic signed [DATA_W-1:0]   rd_data_reg;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic signed [DATA_W-1:0]   res_removed_reg, res_removed_next;
    logic                       m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]        m_status_reg;
    logic signed [DATA_W-1:0]   m_removed_reg;
    logic [OCC_W-1:0]           m_occupancy_reg;

    logic                       wr_en, rd_en;
    logic [CW-1:0]              wr_off, rd_off;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [DATA_W-1:0]          wr_data;
    logic [OW-1:0]              occ_wide;

    // logical offset from the head to a physical slot
    function automatic logic [AW-1:0] phys(input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head_reg) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        wr_en   = cmd.append_write | cmd.shift_write | cmd.place_write;
        wr_off  = count_reg;
        wr_data = op_value_reg;
        if (cmd.shift_write) begin
            wr_off  = ptr_reg;
            wr_data = rd_data_reg;
        end else if (cmd.place_write) begin
            wr_off = pos_reg;
        end
        rd_en  = cmd.scan_read | cmd.shift_read | cmd.pop_read;
        rd_off = '0;
        if (cmd.scan_read) begin
            rd_off = ptr_reg;
        end else if (cmd.shift_read) begin
            rd_off = ptr_reg - CW'(1);
        end
        wr_addr = phys(wr_off);
        rd_addr = phys(rd_off);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next       = count_reg;
        head_next        = head_reg;
        ptr_next         = ptr_reg;
        pos_next         = pos_reg;
        thr_next         = thr_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        m_valid_next     = m_valid_reg;

        if (cfg_valid) begin
            thr_next = cfg_priority_threshold;
        end
        if (cmd.take_item) begin
            res_status_next  = ST_DONE;
            res_removed_next = '0;
        end
        if (cmd.set_full) begin
            res_status_next = ST_FULL;
        end
        if (cmd.set_empty) begin
            res_status_next = ST_EMPTY;
        end
        if (cmd.append_write || cmd.place_write) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop) begin
            count_next       = count_reg - CW'(1);
            head_next        = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            res_removed_next = rd_data_reg;
        end
        if (cmd.scan_start) begin
            ptr_next = '0;
        end
        if (cmd.scan_next) begin
            ptr_next = ptr_reg + CW'(1);
        end
        if (cmd.scan_stop) begin
            pos_next = ptr_reg;
            ptr_next = count_reg;
        end
        if (cmd.shift_write) begin
            ptr_next = ptr_reg - CW'(1);
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    assign occ_wide = OW'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            head_reg    <= '0;
            thr_reg     <= THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            head_reg    <= head_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg         <= ptr_next;
        pos_reg         <= pos_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        if (cmd.take_item) begin
            op_func_reg  <= s_func;
            op_value_reg <= s_item_value;
        end
        if (cmd.load_out) begin
            m_status_reg    <= res_status_reg;
            m_removed_reg   <= res_removed_reg;
            m_occupancy_reg <= occ_wide[OCC_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_reg;
    assign m_occupancy     = m_occupancy_reg;

    always_comb begin
        stat.func         = op_func_reg;
        stat.full         = (count_reg >= CW'(QUEUE_DEPTH));
        stat.empty        = (count_reg == '0);
        stat.item_high    = (op_value_reg > thr_reg);
        stat.rd_high      = (rd_data_reg > thr_reg);
        stat.ptr_at_count = (ptr_reg == count_reg);
        stat.ptr_at_pos   = (ptr_reg == pos_reg);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < AW'(QUEUE_DEPTH - 1) || head_reg == AW'(QUEUE_DEPTH - 1))
        else $error("head pointer out of range");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not lower the count by one");

    a_place_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.place_write |-> ptr_reg == pos_reg && count_reg < CW'(QUEUE_DEPTH))
        else $error("insert placed before the shift finished or into a full store");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_valid_reg || m_ready)
        else $error("result overwritten while still waiting");

endmodule

FILE: test/two_class_priority_queue_top_test.sv
// testbench for two_class_priority_queue_top: directed table, then random bursts
// checked against a shadow queue model; depends on tcpq_pkg and the design files
`timescale 1ns / 1ps

module two_class_priority_queue_top_test;
    import tcpq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int N_DIRECTED   = 15;
    localparam int PHASE_ITEMS  = 105;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    // func code 3 is unused by the block and acts as a no-op
    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [DATA_W-1:0]  removed_value;
        logic [OCC_W-1:0]          occupancy;
    } queue_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [DATA_W-1:0]  value;
        logic [4:0]                reps;
        logic                      typed;
        queue_result_t             want;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func = '0;
    logic signed [DATA_W-1:0]  s_item_value = '0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic signed [DATA_W-1:0]  cfg_priority_threshold = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic signed [DATA_W-1:0]  m_removed_value;
    logic [OCC_W-1:0]          m_occupancy;

    // typed-in expectation travels with the beat, assigned like the payload
    logic                      beat_typed = 1'b0;
    queue_result_t             beat_want = '0;

    logic signed [DATA_W-1:0]  shadow_entries[$];
    logic signed [DATA_W-1:0]  shadow_threshold = THRESHOLD_RESET;
    queue_result_t             pending_outcomes[$];
    stim_row_t                 directed_rows[N_DIRECTED];

    logic hold_off_req = 1'b0;
    int   error_count = 0;
    int   items_done = 0;
    int   results_seen = 0;
    int   threshold_writes = 0;
    int   dropped_full = 0;
    int   empty_removes = 0;

    two_class_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_func                 (s_func),
        .s_item_value           (s_item_value),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_priority_threshold (cfg_priority_threshold),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_removed_value        (m_removed_value),
        .m_occupancy            (m_occupancy)
    );

    always #1 aclk = ~aclk;

    function automatic queue_result_t apply_queue_op(input logic [FUNC_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] value);
        queue_result_t outcome;
        int slot;
        outcome = '0;
        outcome.status = ST_DONE;
        case (op)
            FN_APPEND, FN_PRIO: begin
                if (shadow_entries.size() >= QUEUE_DEPTH) begin
                    outcome.status = ST_FULL;
                end else if (op == FN_PRIO && value > shadow_threshold) begin
                    // land behind the leading run of high entries
                    slot = 0;
                    while (slot < shadow_entries.size() && shadow_entries[slot] > shadow_threshold)
                        slot++;
                    shadow_entries.insert(slot, value);
                end else begin
                    shadow_entries.push_back(value);
                end
            end
            FN_REMOVE: begin
                if (shadow_entries.size() == 0)
                    outcome.status = ST_EMPTY;
                else
                    outcome.removed_value = shadow_entries.pop_front();
            end
            default: ;
        endcase
        outcome.occupancy = OCC_W'(shadow_entries.size());
        return outcome;
    endfunction

    function automatic stim_row_t stim_row(input logic [FUNC_W-1:0] op,
                                           input logic signed [DATA_W-1:0] value,
                                           input int reps, input logic typed,
                                           input logic [STATUS_W-1:0] status,
                                           input logic signed [DATA_W-1:0] removed,
                                           input int occupancy);
        stim_row_t row;
        row.func = op;
        row.value = value;
        row.reps = 5'(reps);
        row.typed = typed;
        row.want.status = status;
        row.want.removed_value = removed;
        row.want.occupancy = OCC_W'(occupancy);
        return row;
    endfunction

    function automatic logic [FUNC_W-1:0] draw_op(input int remove_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return FN_NOP;
        if (roll < 4 + remove_pct)
            return FN_REMOVE;
        return ($urandom_range(0, 2) == 0) ? FN_APPEND : FN_PRIO;
    endfunction

    // values cluster around the threshold so both classes stay busy
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return shadow_threshold;
            3:       return shadow_threshold + 1;
            4:       return shadow_threshold - 1;
            5, 6:    return $urandom;
            default: return shadow_threshold + $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic compare_field(input string field, input logic signed [DATA_W-1:0] want,
                                 input logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    task automatic send_beat(input logic [FUNC_W-1:0] op,
                             input logic signed [DATA_W-1:0] value,
                             input logic typed, input queue_result_t want);
        s_valid      <= 1'b1;
        s_func       <= op;
        s_item_value <= value;
        beat_typed   <= typed;
        beat_want    <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic write_threshold(input logic signed [DATA_W-1:0] threshold);
        s_valid <= 1'b0;
        // let every outstanding result reach the scoreboard first
        @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
        cfg_valid              <= 1'b1;
        cfg_priority_threshold <= threshold;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // scoreboard: results first, then config, then the new operation
    always @(posedge aclk) begin : scoreboard
        queue_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_outcomes.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", DATA_W'(want.status), DATA_W'(m_status));
                    compare_field("removed_value", want.removed_value, m_removed_value);
                    compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(m_occupancy));
                end
            end
            if (cfg_valid && cfg_ready) begin
                shadow_threshold = cfg_priority_threshold;
                threshold_writes++;
            end
            if (s_valid && s_ready) begin
                want = apply_queue_op(s_func, s_item_value);
                items_done++;
                if (want.status == ST_FULL)
                    dropped_full++;
                if (want.status == ST_EMPTY)
                    empty_removes++;
                pending_outcomes.push_back(beat_typed ? beat_want : want);
            end
        end
    end

    // receiver: stretches of random duty, plus one long hold on request
    initial begin : result_pacing
        int stretch;
        int duty;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                stretch = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0, 1:    duty = 100;
                    2:       duty = 70;
                    default: duty = 30;
                endcase
                repeat (stretch) begin
                    if (hold_off_req)
                        break;
                    m_ready <= ($urandom_range(1, 100) <= duty);
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] settings[6];
        logic [FUNC_W-1:0] op;
        int sent;
        int burst;
        int remove_pct;

        directed_rows[0]  = stim_row(FN_REMOVE, 0, 1, 1'b1, ST_EMPTY, 0, 0);
        directed_rows[1]  = stim_row(FN_NOP, -1, 1, 1'b1, ST_DONE, 0, 0);
        directed_rows[2]  = stim_row(FN_APPEND, VAL_MAX, 1, 1'b1, ST_DONE, 0, 1);
        directed_rows[3]  = stim_row(FN_APPEND, VAL_MIN, 1, 1'b1, ST_DONE, 0, 2);
        directed_rows[4]  = stim_row(FN_PRIO, 60, 1, 1'b0, ST_DONE, 0, 0);
        directed_rows[5]  = stim_row(FN_PRIO, 59, 1, 1'b0, ST_DONE, 0, 0);
        directed_rows[6]  = stim_row(FN_PRIO, VAL_MIN, 1, 1'b0, ST_DONE, 0, 0);
        directed_rows[7]  = stim_row(FN_PRIO, VAL_MAX, 1, 1'b0, ST_DONE, 0, 0);
        directed_rows[8]  = stim_row(FN_REMOVE, 0, 1, 1'b1, ST_DONE, VAL_MAX, 5);
        directed_rows[9]  = stim_row(FN_NOP, 0, 1, 1'b0, ST_DONE, 0, 0);
        directed_rows[10] = stim_row(FN_APPEND, 32'sh5555_5555, 14, 1'b0, ST_DONE, 0, 0);
        directed_rows[11] = stim_row(FN_APPEND, -1, 1, 1'b1, ST_FULL, 0, QUEUE_DEPTH);
        directed_rows[12] = stim_row(FN_PRIO, VAL_MAX, 1, 1'b1, ST_FULL, 0, QUEUE_DEPTH);
        directed_rows[13] = stim_row(FN_REMOVE, 32'shAAAA_AAAA, 16, 1'b0, ST_DONE, 0, 0);
        directed_rows[14] = stim_row(FN_REMOVE, 0, 1, 1'b1, ST_EMPTY, 0, 0);

        settings[0] = VAL_MIN;
        settings[1] = VAL_MAX;
        settings[2] = 0;
        settings[3] = -1;
        settings[4] = $urandom;
        settings[5] = THRESHOLD_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            repeat (directed_rows[r].reps)
                send_beat(directed_rows[r].func, directed_rows[r].value,
                          directed_rows[r].typed, directed_rows[r].want);
            pause_sender($urandom_range(0, 2));
        end

        // phase 0 runs at the reset threshold, the rest after a register write
        for (int phase = 0; phase <= 6; phase++) begin
            if (phase > 0)
                write_threshold(settings[phase-1]);
            if (phase == 0) begin
                // back-pressure: receiver holds off while a run of mostly inserts is offered
                hold_off_req = 1'b1;
                repeat (40) send_beat(draw_op(10), draw_value(), 1'b0, '0);
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                case ($urandom_range(0, 2))
                    0:       remove_pct = 15;
                    1:       remove_pct = 40;
                    default: remove_pct = 65;
                endcase
                repeat (burst) begin
                    op = draw_op(remove_pct);
                    send_beat(op, draw_value(), 1'b0, '0);
                    if (op != FN_NOP)
                        sent++;
                end
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d queue operations over %0d threshold settings, %0d results checked",
                 items_done, threshold_writes + 1, results_seen);
        $display("%0d inserts dropped on a full queue, %0d removes hit an empty queue",
                 dropped_full, empty_removes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
